// ===== rtl/ssb_pkg.sv =====
package ssb_pkg;

    localparam int MAX_WEIGHTS_DEF = 6;
    localparam int WEIGHT_BITS_DEF = 16;

    localparam int WEIGHT_W = 16;
    localparam int MASK_W   = 16;
    localparam int COUNT_W  = 6;
    localparam int TARGET_W = 20;
    // Sum plus one weight stays below 2**21 for any legal target and weight set.
    localparam int SUM_W    = 21;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [TARGET_W-1:0] TARGET_RESET   = TARGET_W'(52);
    localparam logic [COUNT_W-1:0]  SOLUTION_LIMIT = COUNT_W'(63);

    // Register index, taken from paddr[2].
    localparam logic REG_TARGET = 1'b0;

    typedef struct packed {
        logic [WEIGHT_W-1:0] weight_value;
        logic                last_weight;
    } t_in_item;

    typedef struct packed {
        logic [MASK_W-1:0]  solution_mask;
        logic               end_of_search;
        logic [COUNT_W-1:0] solution_count;
        logic               truncated;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_FIT,
        ST_DESCEND,
        ST_RETURN,
        ST_FETCH_BACK,
        ST_BACK,
        ST_END
    } t_state;

endpackage

// ===== rtl/subset_sum_backtrack_core.sv =====
// Loading: one weight transaction per cycle; busy stays low until the last weight.
// Search: per tree node the states CHECK, FIT, DESCEND on the way down and RETURN,
// FETCH_BACK, BACK on the way up, at most 2**(N+1) nodes for N loaded weights,
// all sharing one add/subtract unit. The end item is registered on the way out of END.
// Results come out as one-cycle strobes; the receiver cannot stall, so none are buffered.
// Synchronous active-low reset clears control state and sets target to 52.
module subset_sum_backtrack_core #(
    parameter int MAX_WEIGHTS = ssb_pkg::MAX_WEIGHTS_DEF,
    parameter int WEIGHT_BITS = ssb_pkg::WEIGHT_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Command side
    input  logic                                start,
    output logic                                busy,
    input  ssb_pkg::t_in_item                   i_item,
    // Result side
    output logic                                o_result_valid,
    output ssb_pkg::t_result                    o_result,
    // Configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ssb_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [ssb_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [ssb_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);

    // Weights are cut to the narrower of the parameter and the field width.
    localparam int WB_EFF = (WEIGHT_BITS < ssb_pkg::WEIGHT_W) ? WEIGHT_BITS
                                                             : ssb_pkg::WEIGHT_W;
    // Level runs 0..MAX_WEIGHTS; store index covers 0..MAX_WEIGHTS-1.
    localparam int LVL_W = $clog2(MAX_WEIGHTS + 1);
    localparam int IDX_W = (MAX_WEIGHTS > 1) ? $clog2(MAX_WEIGHTS) : 1;
    localparam int SUM_W = ssb_pkg::SUM_W;

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    ssb_pkg::t_state                 r_state, n_state;

    logic [ssb_pkg::TARGET_W-1:0]    r_target;
    logic [WB_EFF-1:0]               r_store [MAX_WEIGHTS];
    logic [WB_EFF-1:0]               r_w;          // weight of the level in work
    logic [LVL_W-1:0]                r_loaded;
    logic [LVL_W-1:0]                r_level;
    logic [SUM_W-1:0]                r_sum;
    logic [SUM_W-1:0]                r_rem;
    logic [ssb_pkg::MASK_W-1:0]      r_mask;
    logic [MAX_WEIGHTS-1:0]          r_branch;     // 1 while the include child is open
    logic [ssb_pkg::COUNT_W-1:0]     r_found;
    logic                            r_trunc;

    logic                            r_out_valid;
    ssb_pkg::t_result                r_out;

    // ------------------------------------------------------------------
    // Shared add/subtract unit and the compares around it
    // ------------------------------------------------------------------
    logic [SUM_W-1:0]                u_a, u_b, u_res;
    logic                            u_sub;

    logic                            accept;
    logic [IDX_W-1:0]                lvl_idx;
    logic [MAX_WEIGHTS-1:0]          lvl_bit;
    logic [SUM_W-1:0]                tgt_ext;
    logic [SUM_W-1:0]                w_ext;
    logic [SUM_W-1:0]                w_in_ext;
    logic                            sum_short;    // sum + remaining < target
    logic                            sum_hit;      // sum == target
    logic                            sum_over;     // sum + weight > target
    logic                            at_leaf;      // no next weight
    logic                            include_open;
    logic                            take_hit;     // hit that is reported
    logic                            cfg_write;

    assign accept       = start && !busy;
    assign lvl_idx      = r_level[IDX_W-1:0];
    assign lvl_bit      = MAX_WEIGHTS'(1) << lvl_idx;
    assign tgt_ext      = SUM_W'(r_target);
    assign w_ext        = SUM_W'(r_w);
    assign w_in_ext     = SUM_W'(i_item.weight_value[WB_EFF-1:0]);
    assign u_res        = u_sub ? (u_a - u_b) : (u_a + u_b);
    assign sum_short    = u_res < tgt_ext;
    assign sum_over     = u_res > tgt_ext;
    assign sum_hit      = r_sum == tgt_ext;
    assign at_leaf      = r_level >= r_loaded;
    assign include_open = |(r_branch & lvl_bit);
    assign take_hit     = (r_state == ssb_pkg::ST_CHECK) && !sum_short && sum_hit
                          && (r_found != ssb_pkg::SOLUTION_LIMIT);

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ssb_pkg::ST_IDLE: begin
                if (accept && i_item.last_weight) n_state = ssb_pkg::ST_CHECK;
            end
            ssb_pkg::ST_CHECK: begin
                if (sum_short) begin
                    n_state = ssb_pkg::ST_RETURN;
                end else if (sum_hit) begin
                    // A hit past the limit stops the whole search.
                    n_state = (r_found == ssb_pkg::SOLUTION_LIMIT) ? ssb_pkg::ST_END
                                                                   : ssb_pkg::ST_RETURN;
                end else if (at_leaf) begin
                    n_state = ssb_pkg::ST_RETURN;
                end else begin
                    n_state = ssb_pkg::ST_FIT;
                end
            end
            ssb_pkg::ST_FIT: begin
                n_state = sum_over ? ssb_pkg::ST_RETURN : ssb_pkg::ST_DESCEND;
            end
            ssb_pkg::ST_DESCEND:    n_state = ssb_pkg::ST_CHECK;
            ssb_pkg::ST_RETURN: begin
                n_state = (r_level == '0) ? ssb_pkg::ST_END : ssb_pkg::ST_FETCH_BACK;
            end
            ssb_pkg::ST_FETCH_BACK: n_state = ssb_pkg::ST_BACK;
            ssb_pkg::ST_BACK: begin
                n_state = include_open ? ssb_pkg::ST_CHECK : ssb_pkg::ST_RETURN;
            end
            ssb_pkg::ST_END:        n_state = ssb_pkg::ST_IDLE;
            default:                n_state = ssb_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Unit operand select per state
    // ------------------------------------------------------------------
    always_comb begin
        u_a   = r_sum;
        u_b   = '0;
        u_sub = 1'b0;
        case (r_state)
            ssb_pkg::ST_IDLE: begin
                // Running total of the loaded weights.
                u_a = r_rem;
                u_b = w_in_ext;
            end
            ssb_pkg::ST_CHECK: begin
                u_a = r_sum;
                u_b = r_rem;
            end
            ssb_pkg::ST_FIT: begin
                u_a = r_sum;
                u_b = w_ext;
            end
            ssb_pkg::ST_DESCEND: begin
                u_a   = r_rem;
                u_b   = w_ext;
                u_sub = 1'b1;
            end
            ssb_pkg::ST_BACK: begin
                // Leaving the include child: drop the weight from the sum.
                // Leaving the exclude child: give the weight back to the remainder.
                u_a   = include_open ? r_sum : r_rem;
                u_b   = w_ext;
                u_sub = include_open;
            end
            default: begin
                u_a   = r_sum;
                u_b   = '0;
                u_sub = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control and datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ssb_pkg::ST_IDLE;
            r_loaded    <= '0;
            r_level     <= '0;
            r_sum       <= '0;
            r_rem       <= '0;
            r_mask      <= '0;
            r_branch    <= '0;
            r_found     <= '0;
            r_trunc     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            // Strobe a reported hit, or the end item on the way out of END.
            r_out_valid <= take_hit || (r_state == ssb_pkg::ST_END);
            case (r_state)
                ssb_pkg::ST_IDLE: begin
                    // Store while there is room; drop extra weights.
                    if (accept && (r_loaded < LVL_W'(MAX_WEIGHTS))) begin
                        r_loaded <= r_loaded + LVL_W'(1);
                        r_rem    <= u_res;
                    end
                end
                ssb_pkg::ST_CHECK: begin
                    if (!sum_short && sum_hit) begin
                        if (r_found == ssb_pkg::SOLUTION_LIMIT) begin
                            r_trunc <= 1'b1;
                        end else begin
                            r_found <= r_found + ssb_pkg::COUNT_W'(1);
                        end
                    end
                end
                ssb_pkg::ST_FIT: begin
                    if (!sum_over) begin
                        r_sum    <= u_res;
                        r_branch <= r_branch | lvl_bit;
                        r_mask   <= r_mask | ssb_pkg::MASK_W'(lvl_bit);
                    end
                end
                ssb_pkg::ST_DESCEND: begin
                    r_rem   <= u_res;
                    r_level <= r_level + LVL_W'(1);
                end
                ssb_pkg::ST_RETURN: begin
                    if (r_level != '0) r_level <= r_level - LVL_W'(1);
                end
                ssb_pkg::ST_BACK: begin
                    if (include_open) begin
                        // Turn to the exclude child one level down.
                        r_sum    <= u_res;
                        r_branch <= r_branch & ~lvl_bit;
                        r_mask   <= r_mask & ~ssb_pkg::MASK_W'(lvl_bit);
                        r_level  <= r_level + LVL_W'(1);
                    end else begin
                        r_rem <= u_res;
                    end
                end
                ssb_pkg::ST_END: begin
                    // Close the search and discard the loaded set.
                    r_loaded    <= '0;
                    r_level     <= '0;
                    r_sum       <= '0;
                    r_rem       <= '0;
                    r_mask      <= '0;
                    r_branch    <= '0;
                    r_found     <= '0;
                    r_trunc     <= 1'b0;
                end
                default: begin
                    r_level <= r_level;
                end
            endcase
        end
    end

    // Payload registers: weight store, working weight and result.
    always_ff @(posedge i_clk) begin
        if ((r_state == ssb_pkg::ST_IDLE) && accept
                && (r_loaded < LVL_W'(MAX_WEIGHTS))) begin
            r_store[r_loaded[IDX_W-1:0]] <= i_item.weight_value[WB_EFF-1:0];
        end
        // Fetch the next weight ahead of FIT, or the parent's weight ahead of BACK.
        if (((r_state == ssb_pkg::ST_CHECK) && !at_leaf)
                || (r_state == ssb_pkg::ST_FETCH_BACK)) begin
            r_w <= r_store[lvl_idx];
        end
        if (r_state == ssb_pkg::ST_CHECK) begin
            r_out.solution_mask  <= r_mask;
            r_out.end_of_search  <= 1'b0;
            r_out.solution_count <= '0;
            r_out.truncated      <= 1'b0;
        end else if (r_state == ssb_pkg::ST_END) begin
            r_out.solution_mask  <= '0;
            r_out.end_of_search  <= 1'b1;
            r_out.solution_count <= r_found;
            r_out.truncated      <= r_trunc;
        end
    end

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= ssb_pkg::TARGET_RESET;
        end else if (cfg_write && (paddr[2] == ssb_pkg::REG_TARGET)) begin
            r_target <= pwdata[ssb_pkg::TARGET_W-1:0];
        end
    end

    assign prdata = (paddr[2] == ssb_pkg::REG_TARGET) ? ssb_pkg::APB_DATA_W'(r_target)
                                                      : '0;
    assign pready = 1'b1;

    // ------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------
    assign busy           = (r_state != ssb_pkg::ST_IDLE);
    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // The search only descends when the weight fits, so the sum never passes the target.
    a_sum_within_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ssb_pkg::ST_CHECK) |-> (r_sum <= tgt_ext))
        else $error("partial sum exceeds target during search");

    // The end item leaves the block idle with the weight set discarded.
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.end_of_search) |->
            ((r_state == ssb_pkg::ST_IDLE) && (r_loaded == '0) && (r_branch == '0)))
        else $error("end item without a cleared search");

    // Busy drops only together with the end item.
    a_busy_ends_with_end_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(busy) && $past(i_rst_n)) |-> (o_result_valid && o_result.end_of_search))
        else $error("search closed without an end item");

endmodule

// ===== dv/subset_sum_backtrack_core_tb.sv =====
module subset_sum_backtrack_core_tb;

    // Spare register slot: index 1 decodes to nothing and must ignore writes.
    localparam logic REG_SPARE = 1'b1;
    localparam int   STACK_D   = 16;

    typedef enum {ROW_ITEM, ROW_TARGET} t_row_kind;

    // One row of the directed table. A row with typed set carries its expected
    // outcome inline: typed_hits solution transactions (0 or 1) with typed_mask,
    // then the end transaction with typed_count.
    typedef struct {
        t_row_kind   kind;
        logic [31:0] value;
        logic        last;
        bit          typed;
        int          typed_hits;
        logic [15:0] typed_mask;
        logic [5:0]  typed_count;
    } t_row;

    logic                           i_clk;
    logic                           i_rst_n = 1'b0;
    logic                           start   = 1'b0;
    logic                           busy;
    ssb_pkg::t_in_item              item_in = '0;
    logic                           o_result_valid;
    ssb_pkg::t_result               o_result;
    logic                           psel    = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite  = 1'b0;
    logic [ssb_pkg::APB_ADDR_W-1:0] paddr   = '0;
    logic [ssb_pkg::APB_DATA_W-1:0] pwdata  = '0;
    logic [ssb_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    // Shadow of the block: target register and the weights loaded so far.
    logic [ssb_pkg::TARGET_W-1:0]   target_now = ssb_pkg::TARGET_RESET;
    logic [ssb_pkg::WEIGHT_W-1:0]   loaded_w[ssb_pkg::MAX_WEIGHTS_DEF];
    int                             loaded_n = 0;

    ssb_pkg::t_result               search_out[$];   // results of the latest search
    ssb_pkg::t_result               due_results[$];  // results still to arrive, oldest first
    t_row                           directed[$];

    int errors      = 0;
    int n_items     = 0;
    int n_searches  = 0;
    int n_solutions = 0;
    int top_hits    = 0;

    subset_sum_backtrack_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (item_in),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        errors++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic check_field(input string field, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h want %0h", field, got, want));
    endtask

    function automatic ssb_pkg::t_result make_result(input logic [15:0] mask,
                                                     input logic last,
                                                     input logic [5:0] count,
                                                     input logic trunc);
        ssb_pkg::t_result r;
        r.solution_mask  = mask;
        r.end_of_search  = last;
        r.solution_count = count;
        r.truncated      = trunc;
        return r;
    endfunction

    // Depth-first sum-of-subsets search over the loaded weights, include branch
    // before exclude branch. An explicit stack replaces recursion; pushing the
    // exclude child under the include child keeps the visiting order.
    task automatic search_subsets();
        int unsigned st_lvl[STACK_D], st_sum[STACK_D], st_rem[STACK_D];
        logic [15:0] st_mask[STACK_D];
        int unsigned lvl, sum, rem, wl, total, tgt;
        logic [15:0] mask;
        int          sp, hits, i;
        bit          trunc;
        search_out.delete();
        total = 0;
        for (i = 0; i < loaded_n; i++)
            total += 32'(loaded_w[i]);
        tgt = 32'(target_now);
        st_lvl[0] = 0;
        st_sum[0] = 0;
        st_rem[0] = total;
        st_mask[0] = '0;
        sp = 1;
        hits = 0;
        trunc = 1'b0;
        while (sp > 0 && !trunc) begin
            sp--;
            lvl = st_lvl[sp];
            sum = st_sum[sp];
            rem = st_rem[sp];
            mask = st_mask[sp];
            // Drop the node when even taking everything left cannot reach the target.
            if (sum + rem < tgt)
                continue;
            if (sum == tgt) begin
                // A hit ends this branch; the one past the limit stops the search.
                if (hits >= int'(ssb_pkg::SOLUTION_LIMIT))
                    trunc = 1'b1;
                else begin
                    search_out.push_back(make_result(mask, 1'b0, '0, 1'b0));
                    hits++;
                end
                continue;
            end
            // No next weight left: the node is unpromising.
            if (lvl >= loaded_n)
                continue;
            wl = 32'(loaded_w[lvl]);
            if (sum + wl > tgt)
                continue;
            st_lvl[sp] = lvl + 1;
            st_sum[sp] = sum;
            st_rem[sp] = rem - wl;
            st_mask[sp] = mask;
            st_lvl[sp + 1] = lvl + 1;
            st_sum[sp + 1] = sum + wl;
            st_rem[sp + 1] = rem - wl;
            st_mask[sp + 1] = mask | (16'd1 << lvl);
            sp += 2;
        end
        search_out.push_back(make_result('0, 1'b1, 6'(hits), trunc));
        if (hits > top_hits)
            top_hits = hits;
    endtask

    // Track one accepted weight; on the last mark run the search and drop the set.
    task automatic track_weight(input ssb_pkg::t_in_item it);
        search_out.delete();
        if (loaded_n < ssb_pkg::MAX_WEIGHTS_DEF) begin
            loaded_w[loaded_n] = it.weight_value;
            loaded_n++;
        end
        if (it.last_weight) begin
            search_subsets();
            loaded_n = 0;
        end
    endtask

    // Offer one weight; hold start and data until the transaction is taken.
    task automatic send_item(input ssb_pkg::t_in_item it, input int idle_pct);
        while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        item_in <= it;
        do @(posedge i_clk); while (busy !== 1'b0);
        n_items++;
        track_weight(it);
    endtask

    function automatic void expect_search();
        foreach (search_out[i])
            due_results.push_back(search_out[i]);
    endfunction

    // One APB transaction: setup cycle, access cycle, then release the bus.
    task automatic apb_xfer(input logic wr, input logic [ssb_pkg::APB_ADDR_W-1:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Write the target with junk in the unused upper bits, then read it back.
    task automatic write_target(input logic [ssb_pkg::TARGET_W-1:0] value);
        logic [31:0] rd;
        apb_xfer(1'b1, {ssb_pkg::REG_TARGET, 2'b00},
                 ($urandom() & 32'hFFF0_0000) | 32'(value), rd);
        target_now = value;
        apb_xfer(1'b0, {ssb_pkg::REG_TARGET, 2'b00}, '0, rd);
        check_field("target readback", 32'(rd[ssb_pkg::TARGET_W-1:0]), 32'(value));
    endtask

    // Pause the sender until every expected transaction has come and the block is idle.
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (due_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        while (busy !== 1'b0)
            @(posedge i_clk);
    endtask

    function automatic void add_row(input t_row_kind kind, input logic [31:0] value,
                                    input logic last, input bit typed, input int hits,
                                    input logic [15:0] mask, input logic [5:0] count);
        t_row r;
        r.kind = kind;
        r.value = value;
        r.last = last;
        r.typed = typed;
        r.typed_hits = hits;
        r.typed_mask = mask;
        r.typed_count = count;
        directed.push_back(r);
    endfunction

    // One set of weights: mostly sorted sets built so that some subset hits the
    // target, some dense sets of repeated values for many hits, the rest noise.
    task automatic send_set(input int unsigned tgt, input int idle_pct, inout int budget);
        logic [15:0]       w[8];
        logic [15:0]       tmp;
        ssb_pkg::t_in_item it;
        int                n, k, kmin, mode, i, j;
        int unsigned       mid, d, acc, a, cap;
        mode = $urandom_range(0, 99);
        n = $urandom_range(1, 6);
        if ($urandom_range(0, 9) == 0)
            n = $urandom_range(7, 8);
        cap = (tgt < 65535) ? tgt : 65535;
        if (mode < 15) begin
            // Noise: any values in any order.
            for (i = 0; i < n; i++)
                w[i] = 16'($urandom_range(0, 65535));
        end else if (mode < 40 && tgt <= 65535) begin
            a = $urandom_range(0, tgt);
            for (i = 0; i < n; i++)
                case ($urandom_range(0, 3))
                    0: w[i] = '0;
                    1: w[i] = 16'(a);
                    2: w[i] = 16'(tgt - a);
                    default: w[i] = 16'(tgt);
                endcase
        end else begin
            kmin = (tgt + 65534) / 65535;
            if (kmin < 1)
                kmin = 1;
            if (n < kmin)
                n = kmin;
            k = $urandom_range(kmin, (n > 6) ? 6 : n);
            mid = tgt / k;
            d = ((mid < 65535 - mid) ? mid : 65535 - mid) / 2;
            acc = 0;
            for (i = 0; i < k - 1; i++) begin
                w[i] = 16'($urandom_range(mid - d, mid + d));
                acc += 32'(w[i]);
            end
            w[k - 1] = (acc <= tgt && tgt - acc <= 65535) ? 16'(tgt - acc) : 16'(mid);
            for (i = k; i < n; i++)
                w[i] = 16'($urandom_range(0, cap));
        end
        // Sort everything but the noise into nondecreasing order.
        if (mode >= 15)
            for (i = 0; i < n - 1; i++)
                for (j = 0; j < n - 1 - i; j++)
                    if (w[j] > w[j + 1]) begin
                        tmp = w[j];
                        w[j] = w[j + 1];
                        w[j + 1] = tmp;
                    end
        for (i = 0; i < n; i++) begin
            it.weight_value = w[i];
            it.last_weight = (i == n - 1);
            send_item(it, idle_pct);
            expect_search();
        end
        budget -= n;
    endtask

    task automatic run_phase(input logic [ssb_pkg::TARGET_W-1:0] tgt, input int idle_pct,
                             input int items);
        int budget;
        budget = items;
        drain();
        write_target(tgt);
        while (budget > 0)
            send_set(32'(tgt), idle_pct, budget);
    endtask

    // Compare each result transaction with the oldest expectation.
    always @(posedge i_clk) begin : result_check
        ssb_pkg::t_result want;
        if (i_rst_n && o_result_valid !== 1'b0) begin
            if (due_results.size() == 0)
                report_mismatch($sformatf("unexpected result %h", o_result));
            else begin
                want = due_results.pop_front();
                check_field("solution_mask", 32'(o_result.solution_mask),
                            32'(want.solution_mask));
                check_field("end_of_search", 32'(o_result.end_of_search),
                            32'(want.end_of_search));
                check_field("solution_count", 32'(o_result.solution_count),
                            32'(want.solution_count));
                check_field("truncated", 32'(o_result.truncated), 32'(want.truncated));
            end
            if (o_result.end_of_search === 1'b1)
                n_searches++;
            else
                n_solutions++;
        end
    end

    initial begin : stimulus
        logic [31:0]       rd;
        ssb_pkg::t_in_item it;
        ssb_pkg::t_result  end_res;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Check the reset target, then hit the spare slot and make sure it is ignored.
        apb_xfer(1'b0, {ssb_pkg::REG_TARGET, 2'b00}, '0, rd);
        check_field("target after reset", 32'(rd[ssb_pkg::TARGET_W-1:0]), 32'd52);
        apb_xfer(1'b1, {REG_SPARE, 2'b00}, 32'hFFFF_FFFF, rd);
        apb_xfer(1'b0, {ssb_pkg::REG_TARGET, 2'b00}, '0, rd);
        check_field("target after spare write", 32'(rd[ssb_pkg::TARGET_W-1:0]), 32'd52);

        // Directed table, reset target 52 first.
        add_row(ROW_ITEM, 32'd52, 1'b1, 1'b1, 1, 16'h0001, 6'd1);  // single exact weight
        add_row(ROW_ITEM, 32'd0, 1'b1, 1'b1, 0, '0, 6'd0);         // total below target
        add_row(ROW_ITEM, 32'd10, 1'b0, 1'b0, 0, '0, '0);
        add_row(ROW_ITEM, 32'd20, 1'b0, 1'b0, 0, '0, '0);
        add_row(ROW_ITEM, 32'd22, 1'b0, 1'b0, 0, '0, '0);
        add_row(ROW_ITEM, 32'd30, 1'b1, 1'b0, 0, '0, '0);
        // Zero target: the empty subset at the root is the only solution.
        add_row(ROW_TARGET, 32'd0, 1'b0, 1'b0, 0, '0, '0);
        add_row(ROW_ITEM, 32'd5, 1'b0, 1'b0, 0, '0, '0);
        add_row(ROW_ITEM, 32'd7, 1'b1, 1'b1, 1, 16'h0000, 6'd1);
        // Largest target: unreachable even with every weight at its maximum.
        add_row(ROW_TARGET, 32'h000F_FFFF, 1'b0, 1'b0, 0, '0, '0);
        repeat (5) add_row(ROW_ITEM, 32'h0000_FFFF, 1'b0, 1'b0, 0, '0, '0);
        add_row(ROW_ITEM, 32'h0000_FFFF, 1'b1, 1'b1, 0, '0, 6'd0);
        // Zero weight in the set, and two extra weights dropped, the last one
        // carrying the mark that starts the search.
        add_row(ROW_TARGET, 32'd3, 1'b0, 1'b0, 0, '0, '0);
        add_row(ROW_ITEM, 32'd0, 1'b0, 1'b0, 0, '0, '0);
        repeat (6) add_row(ROW_ITEM, 32'd1, 1'b0, 1'b0, 0, '0, '0);
        add_row(ROW_ITEM, 32'd2, 1'b1, 1'b0, 0, '0, '0);

        foreach (directed[r]) begin
            if (directed[r].kind == ROW_TARGET) begin
                drain();
                write_target(directed[r].value[ssb_pkg::TARGET_W-1:0]);
            end else begin
                it.weight_value = directed[r].value[ssb_pkg::WEIGHT_W-1:0];
                it.last_weight = directed[r].last;
                send_item(it, 0);
                if (directed[r].typed && directed[r].last) begin
                    if (directed[r].typed_hits != 0)
                        due_results.push_back(make_result(directed[r].typed_mask,
                                                          1'b0, '0, 1'b0));
                    end_res = make_result('0, 1'b1, directed[r].typed_count, 1'b0);
                    due_results.push_back(end_res);
                end else
                    expect_search();
            end
        end

        // Random phases: no idling, heavy idling, light idling, heavy again.
        run_phase(20'd52, 0, 50);
        run_phase(20'd1000, 45, 45);
        run_phase(20'd60000, 7, 35);
        run_phase(20'd250000, 45, 30);
        drain();
        repeat (20) @(posedge i_clk);

        if (due_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", due_results.size()));
        $display("covered %0d weight transactions, %0d searches, %0d solutions (%0d max)",
                 n_items, n_searches, n_solutions, top_hits);
        $display("targets from 0 to the maximum, overflowing and zero-weight sets, "
                 , "sender idling at 0, 7 and 45 percent");
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
